// File: rtl/tccs_pkg.sv
// tccs_pkg: shared constants, types and controller codes of the text console core
// used by every file of the block; no dependencies
`timescale 1ns / 1ps

package tccs_pkg;

   localparam int COLS     = 80;
   localparam int ROWS     = 25;
   localparam int TAB      = 8;
   localparam int CELLS    = ROWS * COLS;

   localparam int POS_W    = 11;
   localparam int WIDE_W   = POS_W + 1;
   localparam int COL_W    = $clog2(COLS);
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int CELL_W   = CHAR_W + ATTR_W;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [WIDE_W-1:0] wide_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [ATTR_W-1:0] attr_type;
   typedef logic [CELL_W-1:0] cell_type;

   localparam pos_type  CELLS_POS     = pos_type'(CELLS);
   localparam pos_type  LAST_ROW_POS  = pos_type'(CELLS - COLS);
   localparam pos_type  CLEAR_END_POS = pos_type'(CELLS - 1);
   localparam pos_type  COLS_POS      = pos_type'(COLS);
   localparam wide_type CELLS_WIDE    = wide_type'(CELLS);
   localparam wide_type COLS_WIDE     = wide_type'(COLS);
   localparam wide_type TAB_WIDE      = wide_type'(TAB);

   localparam attr_type ATTR_RESET = attr_type'(7);

   localparam char_type CH_NEWLINE = char_type'(10);
   localparam char_type CH_RETURN  = char_type'(13);
   localparam char_type CH_TAB     = char_type'(9);

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ_WAIT,
      ST_COPY,
      ST_ZERO,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic cap_read;
      logic cnt_clr;
      logic clear_step;
      logic copy_step;
      logic zero_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic addr_ok;
      logic will_scroll;
      logic clear_end;
      logic copy_end;
      logic zero_end;
      logic rsp_free;
   } status_type;

endpackage

// File: rtl/tccs_req_if.sv
// tccs_req_if: request channel, put or read item with valid/ready handshake
// depends on tccs_pkg
`timescale 1ns / 1ps

interface tccs_req_if;
   logic                valid;
   logic                ready;
   logic                opcode;
   tccs_pkg::char_type  char_code;
   tccs_pkg::pos_type   read_addr;

   modport source (output valid, output opcode, output char_code, output read_addr,
                   input ready);
   modport sink   (input valid, input opcode, input char_code, input read_addr,
                   output ready);
endinterface

// File: rtl/tccs_rsp_if.sv
// tccs_rsp_if: response channel, cursor, cell data and scroll flag
// depends on tccs_pkg
`timescale 1ns / 1ps

interface tccs_rsp_if;
   logic                valid;
   logic                ready;
   tccs_pkg::pos_type   cursor_pos;
   tccs_pkg::cell_type  read_data;
   logic                scrolled;

   modport source (output valid, output cursor_pos, output read_data, output scrolled,
                   input ready);
   modport sink   (input valid, input cursor_pos, input read_data, input scrolled,
                   output ready);
endinterface

// File: rtl/tccs_csr_if.sv
// tccs_csr_if: configuration write channel carrying the attribute byte
// depends on tccs_pkg
`timescale 1ns / 1ps

interface tccs_csr_if;
   logic                valid;
   logic                ready;
   tccs_pkg::attr_type  attribute;

   modport source (output valid, output attribute, input ready);
   modport sink   (input valid, input attribute, output ready);
endinterface

// File: rtl/tccs_ctrl.sv
// tccs_ctrl: sequencer for clearing, item execution, scroll copy and last-row zeroing, and response hand-off
// depends on tccs_pkg
`timescale 1ns / 1ps

module tccs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tccs_pkg::status_type status,
   output tccs_pkg::cmd_type    cmd
);

   tccs_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tccs_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         tccs_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_end) begin
               state_in = tccs_pkg::ST_IDLE;
            end
         end
         tccs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = tccs_pkg::ST_EXEC;
            end
         end
         tccs_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.is_read) begin
               state_in = status.addr_ok ? tccs_pkg::ST_READ_WAIT : tccs_pkg::ST_DONE;
            end else if (status.will_scroll) begin
               cmd.cnt_clr = 1'b1;
               state_in    = tccs_pkg::ST_COPY;
            end else begin
               state_in = tccs_pkg::ST_DONE;
            end
         end
         tccs_pkg::ST_READ_WAIT: begin
            cmd.cap_read = 1'b1;
            state_in     = tccs_pkg::ST_DONE;
         end
         tccs_pkg::ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.copy_end) begin
               state_in = tccs_pkg::ST_ZERO;
            end
         end
         tccs_pkg::ST_ZERO: begin
            cmd.zero_step = 1'b1;
            if (status.zero_end) begin
               state_in = tccs_pkg::ST_DONE;
            end
         end
         tccs_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = tccs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tccs_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

// File: rtl/tccs_datapath.sv
// tccs_datapath: screen memory, cursor arithmetic, sweep counter and response register
// depends on tccs_pkg; driven by tccs_ctrl through cmd_type, reports through status_type
`timescale 1ns / 1ps

module tccs_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  tccs_pkg::cmd_type    cmd,
   output tccs_pkg::status_type status,
   input  logic                 req_opcode,
   input  tccs_pkg::char_type   req_char_code,
   input  tccs_pkg::pos_type    req_read_addr,
   input  logic                 csr_write,
   input  tccs_pkg::attr_type   csr_attribute,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tccs_pkg::pos_type    rsp_cursor_pos,
   output tccs_pkg::cell_type   rsp_read_data,
   output logic                 rsp_scrolled
);

   tccs_pkg::attr_type  attr_ff;
   tccs_pkg::pos_type   cursor_ff, cursor_in;
   tccs_pkg::col_type   col_ff, col_in;
   tccs_pkg::pos_type   cnt_ff;
   logic                rsp_valid_ff;

   logic                op_ff;
   tccs_pkg::char_type  ch_ff;
   tccs_pkg::pos_type   addr_ff;
   tccs_pkg::cell_type  data_ff;
   logic                scroll_ff;
   tccs_pkg::pos_type   rsp_cursor_ff;
   tccs_pkg::cell_type  rsp_data_ff;
   logic                rsp_scroll_ff;

   tccs_pkg::cell_type  mem_q [tccs_pkg::CELLS];
   tccs_pkg::cell_type  rd_q;

   tccs_pkg::wide_type  cur_w, col_w, tab_sum, next_w, delta_w, col_sum;
   logic                is_ctrl_char;
   logic                will_scroll;

   logic                mem_we;
   tccs_pkg::pos_type   mem_wa;
   tccs_pkg::cell_type  mem_wd;
   tccs_pkg::pos_type   mem_ra;

   // cursor arithmetic for a put; the column is tracked beside the cursor
   always_comb begin
      cur_w        = tccs_pkg::wide_type'(cursor_ff);
      col_w        = tccs_pkg::wide_type'(col_ff);
      tab_sum      = cur_w + tccs_pkg::TAB_WIDE;
      is_ctrl_char = ch_ff inside {tccs_pkg::CH_NEWLINE, tccs_pkg::CH_RETURN,
                                   tccs_pkg::CH_TAB};
      case (ch_ff)
         tccs_pkg::CH_NEWLINE: next_w = cur_w - col_w + tccs_pkg::COLS_WIDE;
         tccs_pkg::CH_RETURN:  next_w = cur_w - col_w;
         tccs_pkg::CH_TAB:     next_w = tab_sum - (tab_sum % tccs_pkg::TAB_WIDE);
         default:              next_w = cur_w + tccs_pkg::wide_type'(1);
      endcase
      // tab and character steps are shorter than a row, so one wrap is enough
      delta_w = next_w - cur_w;
      col_sum = col_w + delta_w;
      if (col_sum >= tccs_pkg::COLS_WIDE) begin
         col_sum = col_sum - tccs_pkg::COLS_WIDE;
      end
      will_scroll = (next_w >= tccs_pkg::CELLS_WIDE);
   end

   always_comb begin
      cursor_in = cursor_ff;
      col_in    = col_ff;
      if (cmd.exec && (op_ff == tccs_pkg::OP_PUT)) begin
         if (will_scroll) begin
            cursor_in = tccs_pkg::LAST_ROW_POS;
            col_in    = '0;
         end else begin
            cursor_in = tccs_pkg::pos_type'(next_w);
            if ((ch_ff == tccs_pkg::CH_NEWLINE) || (ch_ff == tccs_pkg::CH_RETURN)) begin
               col_in = '0;
            end else begin
               col_in = tccs_pkg::col_type'(col_sum);
            end
         end
      end
   end

   // memory port selection
   always_comb begin
      mem_we = 1'b0;
      mem_wa = cnt_ff;
      mem_wd = '0;
      mem_ra = addr_ff;
      if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (cmd.zero_step) begin
         mem_we = 1'b1;
         mem_wa = cnt_ff - tccs_pkg::pos_type'(1);
      end else if (cmd.copy_step) begin
         // read one row ahead, write the cell fetched in the previous cycle
         mem_we = (cnt_ff != '0);
         mem_wa = cnt_ff - tccs_pkg::pos_type'(1);
         mem_wd = rd_q;
         mem_ra = cnt_ff + tccs_pkg::COLS_POS;
      end else if (cmd.exec) begin
         mem_we = (op_ff == tccs_pkg::OP_PUT) && !is_ctrl_char &&
                  (cursor_ff < tccs_pkg::CELLS_POS);
         mem_wa = cursor_ff;
         mem_wd = {attr_ff, ch_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_q[mem_wa] <= mem_wd;
      end
      if (mem_ra < tccs_pkg::CELLS_POS) begin
         rd_q <= mem_q[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= tccs_pkg::ATTR_RESET;
         cursor_ff    <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            attr_ff <= csr_attribute;
         end
         cursor_ff <= cursor_in;
         col_ff    <= col_in;
         if (cmd.cnt_clr) begin
            cnt_ff <= '0;
         end else if (cmd.clear_step || cmd.copy_step || cmd.zero_step) begin
            cnt_ff <= cnt_ff + tccs_pkg::pos_type'(1);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_opcode;
         ch_ff   <= req_char_code;
         addr_ff <= req_read_addr;
      end
      if (cmd.exec) begin
         data_ff   <= '0;
         scroll_ff <= (op_ff == tccs_pkg::OP_PUT) && will_scroll;
      end
      if (cmd.cap_read) begin
         data_ff <= rd_q;
      end
      if (cmd.load_rsp) begin
         rsp_cursor_ff <= cursor_ff;
         rsp_data_ff   <= data_ff;
         rsp_scroll_ff <= scroll_ff;
      end
   end

   always_comb begin
      status.is_read     = (op_ff == tccs_pkg::OP_READ);
      status.addr_ok     = (addr_ff < tccs_pkg::CELLS_POS);
      status.will_scroll = will_scroll;
      status.clear_end   = (cnt_ff == tccs_pkg::CLEAR_END_POS);
      status.copy_end    = (cnt_ff == tccs_pkg::LAST_ROW_POS);
      status.zero_end    = (cnt_ff == tccs_pkg::CELLS_POS);
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_cursor_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_scrolled   = rsp_scroll_ff;

endmodule

// File: rtl/text_console_cursor_scroll_core.sv
// text_console_cursor_scroll_core: top level of the text console, controller plus datapath
// depends on tccs_pkg, tccs_req_if, tccs_rsp_if, tccs_csr_if, tccs_ctrl, tccs_datapath
`timescale 1ns / 1ps

// Text console of COLS by ROWS 16-bit cells with a linear cursor. One item is
// handled at a time: a put's result passes through EXEC and DONE and a read's
// through EXEC, READ_WAIT if its address is on the screen, and DONE (READ_WAIT waits
// on the registered port of the screen memory) before it is loaded, and DONE holds
// while the output register is full; the input is ready again in the same cycle as
// the result is offered. A put that runs past the last row also scrolls, in COPY and
// ZERO before DONE: the screen memory has one write port, so the rows are copied up
// cell by cell and the last row is then cleared. After reset a clearing pass writes
// zero to every cell, during which req_chan.ready stays low. The next item is taken
// while a result still waits in the output register. csr_chan is always ready.

module text_console_cursor_scroll_core (
   input  logic       clock,
   input  logic       reset,
   tccs_req_if.sink   req_chan,
   tccs_rsp_if.source rsp_chan,
   tccs_csr_if.sink   csr_chan
);

   tccs_pkg::cmd_type    cmd;
   tccs_pkg::status_type status;

   assign csr_chan.ready = 1'b1;

   tccs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tccs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_chan.opcode),
      .req_char_code  (req_chan.char_code),
      .req_read_addr  (req_chan.read_addr),
      .csr_write      (csr_chan.valid),
      .csr_attribute  (csr_chan.attribute),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_cursor_pos (rsp_chan.cursor_pos),
      .rsp_read_data  (rsp_chan.read_data),
      .rsp_scrolled   (rsp_chan.scrolled)
   );

   // the cursor never rests past the screen
   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.cursor_pos < tccs_pkg::CELLS_POS))
      else $error("cursor reported beyond the screen");

   // a scroll leaves the cursor at the start of the last row and no cell data
   a_scroll_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.scrolled) |->
         ((rsp_chan.cursor_pos == tccs_pkg::LAST_ROW_POS) && (rsp_chan.read_data == '0)))
      else $error("scroll result inconsistent");

   // no result can be loaded in the cycle right after an item is taken
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !cmd.load_rsp)
      else $error("result loaded before the item was executed");

endmodule
